FILE: hw/rtl/lavb_pkg.sv
// shared constants and latency helper for the look-at view basis block
package lavb_pkg;

  // the or of the normalised magnitudes sits in [2^29, 2^30)
  localparam int NORM_BITS  = 30;
  localparam int NORM_TOP   = NORM_BITS - 1;
  // one root bit per square-root stage
  localparam int SQRT_STEPS = NORM_BITS + 1;
  // leading-one search works on bytes
  localparam int CHUNK      = 8;
  // fixed stages of the normaliser: abs, byte search, pick, shift, square, sum,
  // divider setup and output
  localparam int NORM_FIXED = 8;

  // cycles from a normaliser input to its output
  function automatic int norm_latency(input int ofb);
    return NORM_FIXED + SQRT_STEPS + ofb + 1;
  endfunction

endpackage

FILE: hw/rtl/lavb_norm3.sv
// pipelined three-component vector normaliser
module lavb_norm3 #(
  parameter int W   = 24,
  parameter int OFB = 14
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [W-1:0]  v [3],
  output logic                 out_valid,
  output logic signed [OFB+1:0] u [3]
);

  localparam int MB   = lavb_pkg::NORM_BITS;
  localparam int NC   = (W + lavb_pkg::CHUNK - 1) / lavb_pkg::CHUNK;
  localparam int OWW  = NC * lavb_pkg::CHUNK;
  localparam int MW   = W + MB;
  localparam int SB   = 2 * MB + 2;
  localparam int RB   = lavb_pkg::SQRT_STEPS;
  localparam int RW   = RB + 3;
  localparam int DIVB = OFB + 1;
  localparam int NB   = MB + OFB + 1;
  localparam int OB   = OFB + 2;

  // stage 1: magnitudes and signs
  logic         s1_valid;
  logic         s1_neg [3];
  logic [W-1:0] s1_m [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_neg[i] <= v[i][W-1];
        s1_m[i]   <= v[i][W-1] ? $unsigned(-v[i]) : $unsigned(v[i]);
      end
    end
  end

  // stage 2: leading one of each byte of the or of all magnitudes
  logic [OWW-1:0] or_word;
  logic           c2_nz [NC];
  logic [2:0]     c2_pos [NC];
  logic           s2_valid;
  logic           s2_neg [3];
  logic [W-1:0]   s2_m [3];
  logic           s2_nz [NC];
  logic [2:0]     s2_pos [NC];

  always_comb begin
    or_word = OWW'(s1_m[0] | s1_m[1] | s1_m[2]);
    for (int c = 0; c < NC; c++) begin
      c2_nz[c]  = |or_word[c*lavb_pkg::CHUNK +: lavb_pkg::CHUNK];
      c2_pos[c] = 3'd0;
      for (int b = 0; b < lavb_pkg::CHUNK; b++) begin
        if (or_word[c*lavb_pkg::CHUNK + b]) begin
          c2_pos[c] = 3'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_neg <= s1_neg;
      s2_m   <= s1_m;
      s2_nz  <= c2_nz;
      s2_pos <= c2_pos;
    end
  end

  // stage 3: pick the highest busy byte
  logic [6:0]   c3_p;
  logic         c3_zero;
  logic         s3_valid;
  logic         s3_neg [3];
  logic         s3_zero;
  logic [W-1:0] s3_m [3];
  logic [6:0]   s3_p;

  always_comb begin
    c3_p    = 7'd0;
    c3_zero = 1'b1;
    for (int c = 0; c < NC; c++) begin
      if (s2_nz[c]) begin
        c3_p    = 7'(c * lavb_pkg::CHUNK) + 7'(s2_pos[c]);
        c3_zero = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_neg  <= s2_neg;
      s3_m    <= s2_m;
      s3_p    <= c3_p;
      s3_zero <= c3_zero;
    end
  end

  // stage 4: shift all magnitudes together into range
  logic [MW-1:0] ext [3];
  logic [MW-1:0] shifted [3];
  logic          s4_valid;
  logic          s4_neg [3];
  logic          s4_zero;
  logic [MB-1:0] s4_m [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ext[i] = MW'(s3_m[i]);
      if (s3_p >= 7'(lavb_pkg::NORM_TOP)) begin
        shifted[i] = ext[i] >> (s3_p - 7'(lavb_pkg::NORM_TOP));
      end else begin
        shifted[i] = ext[i] << (7'(lavb_pkg::NORM_TOP) - s3_p);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_neg  <= s3_neg;
      s4_zero <= s3_zero;
      for (int i = 0; i < 3; i++) begin
        s4_m[i] <= shifted[i][MB-1:0];
      end
    end
  end

  // stage 5: squares
  logic            s5_valid;
  logic            s5_neg [3];
  logic            s5_zero;
  logic [MB-1:0]   s5_m [3];
  logic [2*MB-1:0] s5_sq [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_neg  <= s4_neg;
      s5_zero <= s4_zero;
      s5_m    <= s4_m;
      for (int i = 0; i < 3; i++) begin
        s5_sq[i] <= s4_m[i] * s4_m[i];
      end
    end
  end

  // stage 6: sum of squares, first square-root slot
  logic          sq_valid [RB+1];
  logic          sq_neg [RB+1][3];
  logic          sq_zero [RB+1];
  logic [MB-1:0] sq_m [RB+1][3];
  logic [SB-1:0] sq_sv [RB+1];
  logic [RW-1:0] sq_rem [RB+1];
  logic [RB-1:0] sq_root [RB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid[0] <= 1'b0;
    end else if (en) begin
      sq_valid[0] <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_neg[0]  <= s5_neg;
      sq_zero[0] <= s5_zero;
      sq_m[0]    <= s5_m;
      sq_sv[0]   <= SB'(s5_sq[0]) + SB'(s5_sq[1]) + SB'(s5_sq[2]);
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
    end
  end

  // square root, one result bit a stage
  for (genvar k = 0; k < RB; k++) begin : g_sqrt
    logic [RW-1:0] remx;
    logic [RW-1:0] trial;
    logic          take;

    always_comb begin
      remx  = {sq_rem[k][RW-3:0], sq_sv[k][SB-1 -: 2]};
      trial = RW'({sq_root[k], 2'b01});
      take  = remx >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_valid[k+1] <= 1'b0;
      end else if (en) begin
        sq_valid[k+1] <= sq_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_neg[k+1]  <= sq_neg[k];
        sq_zero[k+1] <= sq_zero[k];
        sq_m[k+1]    <= sq_m[k];
        sq_sv[k+1]   <= sq_sv[k] << 2;
        sq_rem[k+1]  <= take ? remx - trial : remx;
        sq_root[k+1] <= {sq_root[k][RB-2:0], take};
      end
    end
  end

  // divider setup: numerator with half the divisor added for rounding
  logic          dv_valid [DIVB+1];
  logic          dv_neg [DIVB+1][3];
  logic          dv_zero [DIVB+1];
  logic [RB-1:0] dv_n [DIVB+1];
  logic [NB-1:0] dv_rem [DIVB+1][3];
  logic [OFB:0]  dv_q [DIVB+1][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (en) begin
      dv_valid[0] <= sq_valid[RB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_neg[0]  <= sq_neg[RB];
      dv_zero[0] <= sq_zero[RB];
      dv_n[0]    <= sq_root[RB];
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= (NB'(sq_m[RB][i]) << OFB) + NB'(sq_root[RB] >> 1);
        dv_q[0][i]   <= '0;
      end
    end
  end

  // restoring division, one quotient bit a stage, three lanes
  for (genvar j = 0; j < DIVB; j++) begin : g_div
    localparam int QB = OFB - j;
    logic [NB-1:0] dsub;
    logic          take [3];

    always_comb begin
      dsub = NB'(dv_n[j]) << QB;
      for (int i = 0; i < 3; i++) begin
        take[i] = dv_rem[j][i] >= dsub;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[j+1] <= 1'b0;
      end else if (en) begin
        dv_valid[j+1] <= dv_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_neg[j+1]  <= dv_neg[j];
        dv_zero[j+1] <= dv_zero[j];
        dv_n[j+1]    <= dv_n[j];
        for (int i = 0; i < 3; i++) begin
          dv_rem[j+1][i] <= take[i] ? dv_rem[j][i] - dsub : dv_rem[j][i];
          dv_q[j+1][i]   <= dv_q[j][i] | ((OFB+1)'(take[i]) << QB);
        end
      end
    end
  end

  // output: clamp to one, apply sign, zero vector gives zero
  localparam logic [OFB:0] ONE = {1'b1, OFB'(0)};
  logic [OFB:0] qc [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (dv_q[DIVB][i] > ONE) ? ONE : dv_q[DIVB][i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_valid[DIVB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_zero[DIVB]) begin
          u[i] <= '0;
        end else if (dv_neg[DIVB][i]) begin
          u[i] <= -$signed(OB'(qc[i]));
        end else begin
          u[i] <= $signed(OB'(qc[i]));
        end
      end
    end
  end

endmodule

FILE: hw/rtl/look_at_view_basis.sv
// look-at view basis: forward, side and up rows of a view matrix
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid/in_ready, eye_*, target_*, sky_* | item in
//  out     | out_valid/out_ready, side_*, upward_*,  | item out
//          | forward_*, side_defaulted               |
//
// one item accepted per cycle while in_ready is high; the latency is set
// by the bit-per-stage square root and divider of each of the three
// chained normalisers.
// reset clears every valid bit; payload registers are not reset.
// the pipeline moves as one; an output register plus a skid register let one
// more item complete while a result waits, after which in_ready drops.
module look_at_view_basis #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] eye_x,
  input  logic signed [23:0] eye_y,
  input  logic signed [23:0] eye_z,
  input  logic signed [23:0] target_x,
  input  logic signed [23:0] target_y,
  input  logic signed [23:0] target_z,
  input  logic signed [23:0] sky_x,
  input  logic signed [23:0] sky_y,
  input  logic signed [23:0] sky_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] side_x,
  output logic signed [15:0] side_y,
  output logic signed [15:0] side_z,
  output logic signed [15:0] upward_x,
  output logic signed [15:0] upward_y,
  output logic signed [15:0] upward_z,
  output logic signed [15:0] forward_x,
  output logic signed [15:0] forward_y,
  output logic signed [15:0] forward_z,
  output logic               side_defaulted
);

  localparam int OFB = OUT_FRAC_BITS;
  localparam int OB  = OFB + 2;
  localparam int PB  = 2 * OB;
  localparam int CW  = 2 * OFB + 3;
  localparam int L   = lavb_pkg::norm_latency(OFB);
  localparam logic signed [OB-1:0] ONE = OB'(1) <<< OFB;

  logic en;
  logic skid_valid;

  assign en       = !skid_valid;
  assign in_ready = en;

  // input register: direction vector and sky
  logic               r0_valid;
  logic signed [24:0] r0_d [3];
  logic signed [23:0] r0_sky [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      r0_valid <= 1'b0;
    end else if (en) begin
      r0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r0_d[0]   <= 25'(target_x) - 25'(eye_x);
      r0_d[1]   <= 25'(target_y) - 25'(eye_y);
      r0_d[2]   <= 25'(target_z) - 25'(eye_z);
      r0_sky[0] <= sky_x;
      r0_sky[1] <= sky_y;
      r0_sky[2] <= sky_z;
    end
  end

  // normalise sky and forward side by side
  logic              upn_valid;
  logic              fwd_valid;
  logic signed [OB-1:0] upn [3];
  logic signed [OB-1:0] fwd [3];

  lavb_norm3 #(.W(24), .OFB(OFB)) u_norm_sky (
    .clk(clk), .rst(rst), .en(en), .in_valid(r0_valid), .v(r0_sky),
    .out_valid(upn_valid), .u(upn)
  );

  lavb_norm3 #(.W(25), .OFB(OFB)) u_norm_fwd (
    .clk(clk), .rst(rst), .en(en), .in_valid(r0_valid), .v(r0_d),
    .out_valid(fwd_valid), .u(fwd)
  );

  // first cross product: products
  logic                 a1_valid;
  logic signed [OB-1:0] a1_fwd [3];
  logic signed [PB-1:0] a1_p [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      a1_valid <= 1'b0;
    end else if (en) begin
      a1_valid <= upn_valid && fwd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_fwd  <= fwd;
      a1_p[0] <= upn[1] * fwd[2];
      a1_p[1] <= upn[2] * fwd[1];
      a1_p[2] <= upn[2] * fwd[0];
      a1_p[3] <= upn[0] * fwd[2];
      a1_p[4] <= upn[0] * fwd[1];
      a1_p[5] <= upn[1] * fwd[0];
    end
  end

  // first cross product: differences and zero test
  logic                 b1_valid;
  logic                 b1_flag;
  logic signed [OB-1:0] b1_fwd [3];
  logic signed [CW-1:0] b1_c [3];
  logic signed [CW-1:0] c1 [3];

  always_comb begin
    c1[0] = CW'(a1_p[0] - a1_p[1]);
    c1[1] = CW'(a1_p[2] - a1_p[3]);
    c1[2] = CW'(a1_p[4] - a1_p[5]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else if (en) begin
      b1_valid <= a1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_fwd  <= a1_fwd;
      b1_c    <= c1;
      b1_flag <= (c1[0] == '0) && (c1[1] == '0) && (c1[2] == '0);
    end
  end

  // normalise the side axis, forward and flag wait alongside
  logic                 sn_valid;
  logic signed [OB-1:0] sn [3];
  logic signed [OB-1:0] dc_fwd [L][3];
  logic                 dc_flag [L];

  lavb_norm3 #(.W(CW), .OFB(OFB)) u_norm_side (
    .clk(clk), .rst(rst), .en(en), .in_valid(b1_valid), .v(b1_c),
    .out_valid(sn_valid), .u(sn)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dc_fwd[0]  <= b1_fwd;
      dc_flag[0] <= b1_flag;
      for (int k = 1; k < L; k++) begin
        dc_fwd[k]  <= dc_fwd[k-1];
        dc_flag[k] <= dc_flag[k-1];
      end
    end
  end

  // fall back to (1,0,0) when the cross product vanished
  logic                 m_valid;
  logic                 m_flag;
  logic signed [OB-1:0] m_side [3];
  logic signed [OB-1:0] m_fwd [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= sn_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_fwd  <= dc_fwd[L-1];
      m_flag <= dc_flag[L-1];
      if (dc_flag[L-1]) begin
        m_side[0] <= ONE;
        m_side[1] <= '0;
        m_side[2] <= '0;
      end else begin
        m_side <= sn;
      end
    end
  end

  // second cross product: products
  logic                 a2_valid;
  logic                 a2_flag;
  logic signed [OB-1:0] a2_side [3];
  logic signed [OB-1:0] a2_fwd [3];
  logic signed [PB-1:0] a2_p [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      a2_valid <= 1'b0;
    end else if (en) begin
      a2_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a2_flag <= m_flag;
      a2_side <= m_side;
      a2_fwd  <= m_fwd;
      a2_p[0] <= m_fwd[1] * m_side[2];
      a2_p[1] <= m_fwd[2] * m_side[1];
      a2_p[2] <= m_fwd[2] * m_side[0];
      a2_p[3] <= m_fwd[0] * m_side[2];
      a2_p[4] <= m_fwd[0] * m_side[1];
      a2_p[5] <= m_fwd[1] * m_side[0];
    end
  end

  // second cross product: differences
  logic                 b2_valid;
  logic                 b2_flag;
  logic signed [OB-1:0] b2_side [3];
  logic signed [OB-1:0] b2_fwd [3];
  logic signed [CW-1:0] b2_c [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      b2_valid <= 1'b0;
    end else if (en) begin
      b2_valid <= a2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b2_flag <= a2_flag;
      b2_side <= a2_side;
      b2_fwd  <= a2_fwd;
      b2_c[0] <= CW'(a2_p[0] - a2_p[1]);
      b2_c[1] <= CW'(a2_p[2] - a2_p[3]);
      b2_c[2] <= CW'(a2_p[4] - a2_p[5]);
    end
  end

  // normalise the up axis, the other rows wait alongside
  logic                 tail_valid;
  logic signed [OB-1:0] upw [3];
  logic signed [OB-1:0] du_side [L][3];
  logic signed [OB-1:0] du_fwd [L][3];
  logic                 du_flag [L];

  lavb_norm3 #(.W(CW), .OFB(OFB)) u_norm_up (
    .clk(clk), .rst(rst), .en(en), .in_valid(b2_valid), .v(b2_c),
    .out_valid(tail_valid), .u(upw)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      du_side[0] <= b2_side;
      du_fwd[0]  <= b2_fwd;
      du_flag[0] <= b2_flag;
      for (int k = 1; k < L; k++) begin
        du_side[k] <= du_side[k-1];
        du_fwd[k]  <= du_fwd[k-1];
        du_flag[k] <= du_flag[k-1];
      end
    end
  end

  // output register and skid register
  logic        tail_fire;
  logic [15:0] tail_word [9];
  logic [15:0] out_word [9];
  logic [15:0] skid_word [9];
  logic        out_flag;
  logic        skid_flag;

  assign tail_fire = en && tail_valid;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tail_word[i]     = 16'(du_side[L-1][i]);
      tail_word[3 + i] = 16'(upw[i]);
      tail_word[6 + i] = 16'(du_fwd[L-1][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= tail_fire;
      end
    end else if (tail_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_word <= skid_word;
        out_flag <= skid_flag;
      end else begin
        out_word <= tail_word;
        out_flag <= du_flag[L-1];
      end
    end else if (tail_fire) begin
      skid_word <= tail_word;
      skid_flag <= du_flag[L-1];
    end
  end

  assign side_x         = out_word[0];
  assign side_y         = out_word[1];
  assign side_z         = out_word[2];
  assign upward_x       = out_word[3];
  assign upward_y       = out_word[4];
  assign upward_z       = out_word[5];
  assign forward_x      = out_word[6];
  assign forward_y      = out_word[7];
  assign forward_z      = out_word[8];
  assign side_defaulted = out_flag;

  // checks
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds an item while the output is empty");

  a_skid_only_on_stall : assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready))
    else $error("skid register filled without an output stall");

  a_default_side : assert property (@(posedge clk) disable iff (rst)
    (out_valid && side_defaulted) |-> (side_x == 16'(ONE) && side_y == '0 && side_z == '0))
    else $error("defaulted side axis is not (1,0,0)");

endmodule
